// File: rtl/msbs_pkg.sv
`default_nettype none

package msbs_pkg;

	// Default number of blink slots.
	localparam int SLOTS_DEF = 3;

	// Saturating change counter.
	localparam int COUNT_W = 17;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Operation codes carried by an input item.
	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_SET    = 3'd1,
		OP_REMOVE = 3'd2,
		OP_FORCE  = 3'd3,
		OP_QUERY  = 3'd4
	} op_t;

	// Result kinds.
	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Query answers.
	localparam logic [1:0] QS_NONE   = 2'd0;
	localparam logic [1:0] QS_IDLE   = 2'd1;
	localparam logic [1:0] QS_ACTIVE = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_EXEC,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	// One slot record as held in the slot memory (the id lives in flip-flops).
	typedef struct packed {
		logic [15:0]        on_time;
		logic [15:0]        dark_time;
		logic [15:0]        delay;
		logic [15:0]        cycle_limit;
		logic [COUNT_W-1:0] count;
		logic [31:0]        start;
		logic               started;
		logic               level;
	} slot_rec_t;

	// One accepted input item.
	typedef struct packed {
		op_t         op;
		logic [7:0]  channel_id;
		logic [15:0] on_time;
		logic [15:0] dark_time;
		logic [15:0] cycle_limit;
		logic [15:0] start_delay;
		logic        force_level;
	} item_t;

	// One result item before the last flag is known.
	typedef struct packed {
		logic       kind;
		logic [7:0] channel;
		logic       level;
		logic [1:0] status;
	} event_t;

	// Everything the step unit hands back to the sequencer.
	typedef struct packed {
		logic      rec_we;
		slot_rec_t rec;
		logic      id_we;
		logic [7:0] id;
		logic      ev0_valid;
		event_t    ev0;
		logic      ev1_valid;
		event_t    ev1;
	} step_out_t;

	// True for the operation codes that mean something.
	function automatic logic op_known(input logic [2:0] code);
		logic known;
		begin
			unique case (code)
				OP_TICK, OP_SET, OP_REMOVE, OP_FORCE, OP_QUERY: known = 1'b1;
				default: known = 1'b0;
			endcase
			return known;
		end
	endfunction

	// Change counter increment that sticks at its maximum.
	function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] cnt);
		return (cnt == COUNT_MAX) ? cnt : cnt + COUNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// File: rtl/msbs_cfg.sv
`default_nettype none

module msbs_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [15:0] tick_rate
);

	localparam logic [2:0] ADDR_TICK_RATE = 3'd0;

	logic [15:0] tpm_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == ADDR_TICK_RATE);

	// The single register; writes to other addresses are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q <= '0;
		end else if (wr_en) begin
			tpm_q <= pwdata[15:0];
		end
	end

	// Read back.
	always_comb begin
		prdata = '0;
		if (paddr == ADDR_TICK_RATE) begin
			prdata = {16'd0, tpm_q};
		end
	end

	assign tick_rate = tpm_q;

endmodule

`default_nettype wire

// File: rtl/msbs_slot_mem.sv
`default_nettype none

module msbs_slot_mem #(
	parameter int SLOTS = msbs_pkg::SLOTS_DEF,
	parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rd_en,
	input  wire logic [IDX_W-1:0]     rd_addr,
	output msbs_pkg::slot_rec_t       rd_rec,
	input  wire logic                 wr_en,
	input  wire logic [IDX_W-1:0]     wr_addr,
	input  wire msbs_pkg::slot_rec_t  wr_rec
);

	msbs_pkg::slot_rec_t slot_mem [SLOTS];
	msbs_pkg::slot_rec_t rdata_s1;
	logic [SLOTS-1:0]    written_q;
	logic                rvalid_s1;

	// Record storage, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_rec;
		end
		if (rd_en) begin
			rdata_s1 <= slot_mem[rd_addr];
		end
	end

	// An entry that was never written reads as the reset record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_s1 <= written_q[rd_addr];
			end
		end
	end

	assign rd_rec = rvalid_s1 ? rdata_s1 : '0;

endmodule

`default_nettype wire

// File: rtl/msbs_step.sv
`default_nettype none

module msbs_step (
	input  wire msbs_pkg::item_t      item,
	input  wire logic                 found,
	input  wire logic [7:0]           slot_ch,
	input  wire logic [31:0]          tick_now,
	input  wire msbs_pkg::slot_rec_t  rec,
	input  wire logic [31:0]          prod,
	output msbs_pkg::step_out_t       step
);

	logic [31:0]                 elapsed;
	logic                        expired;
	logic                        fire_start;
	logic                        a_level;
	logic [msbs_pkg::COUNT_W-1:0] a_count;
	logic                        phase_done;
	logic                        next_level;
	logic                        keep;
	msbs_pkg::event_t            ev_start;
	msbs_pkg::event_t            ev_phase;

	// Timer compare: the product was formed from the phase that is running.
	assign elapsed = tick_now - rec.start;
	assign expired = (elapsed >= prod);

	// Delay expiry, then a phase end in the same tick.
	assign fire_start = !rec.started && expired;
	assign a_level    = fire_start ? 1'b1 : rec.level;
	assign a_count    = fire_start ? msbs_pkg::count_inc(rec.count) : rec.count;
	// Right after the start the ON phase has zero ticks elapsed.
	assign phase_done = fire_start ? (rec.on_time == 16'd0) : (rec.started && expired);
	assign next_level = a_level ? (rec.dark_time == 16'd0) : 1'b1;
	assign keep       = (rec.cycle_limit != 16'd0) && ({1'b0, rec.cycle_limit} >= a_count);

	always_comb begin
		ev_start = '{kind: msbs_pkg::KIND_EVENT, channel: slot_ch, level: 1'b1,
			status: msbs_pkg::QS_NONE};
		ev_phase = '{kind: msbs_pkg::KIND_EVENT, channel: slot_ch,
			level: keep ? next_level : 1'b0, status: msbs_pkg::QS_NONE};

		step           = '0;
		step.rec       = rec;
		step.id        = slot_ch;

		unique case (item.op)
			// Advance one slot by one tick.
			msbs_pkg::OP_TICK: begin
				if (slot_ch != 8'd0) begin
					step.rec_we      = 1'b1;
					step.rec.started = rec.started | fire_start;
					step.rec.level   = a_level;
					step.rec.count   = a_count;
					if (fire_start) begin
						step.rec.start = tick_now;
					end
					if (phase_done) begin
						step.rec.start = tick_now;
						step.rec.count = msbs_pkg::count_inc(a_count);
						if (keep) begin
							step.rec.level = next_level;
						end else begin
							step.rec.level   = 1'b0;
							step.rec.started = 1'b0;
							step.id_we       = 1'b1;
							step.id          = 8'd0;
						end
					end
					step.ev0_valid = fire_start | phase_done;
					step.ev0       = fire_start ? ev_start : ev_phase;
					step.ev1_valid = fire_start & phase_done;
					step.ev1       = ev_phase;
				end
			end
			// Reload the slot; a zero delay starts it at once.
			msbs_pkg::OP_SET: begin
				if (found) begin
					step.rec_we           = 1'b1;
					step.rec.on_time      = item.on_time;
					step.rec.dark_time    = item.dark_time;
					step.rec.cycle_limit  = item.cycle_limit;
					step.rec.delay        = item.start_delay;
					step.rec.start        = tick_now;
					step.rec.started      = 1'b0;
					step.rec.count        = '0;
					step.id_we            = 1'b1;
					step.id               = item.channel_id;
					if (item.start_delay == 16'd0) begin
						step.rec.started = 1'b1;
						step.rec.level   = 1'b1;
						step.rec.count   = msbs_pkg::COUNT_W'(1);
						step.ev0_valid   = 1'b1;
						step.ev0         = '{kind: msbs_pkg::KIND_EVENT,
							channel: item.channel_id, level: 1'b1, status: msbs_pkg::QS_NONE};
					end
				end
			end
			// Drive off and free the slot.
			msbs_pkg::OP_REMOVE: begin
				if (found) begin
					step.rec_we      = 1'b1;
					step.rec.level   = 1'b0;
					step.rec.started = 1'b0;
					step.rec.count   = msbs_pkg::count_inc(rec.count);
					step.id_we       = 1'b1;
					step.id          = 8'd0;
					step.ev0_valid   = 1'b1;
					step.ev0         = '{kind: msbs_pkg::KIND_EVENT, channel: slot_ch,
						level: 1'b0, status: msbs_pkg::QS_NONE};
				end
			end
			// Drive the requested level.
			msbs_pkg::OP_FORCE: begin
				if (found) begin
					step.rec_we    = 1'b1;
					step.rec.level = item.force_level;
					step.rec.count = msbs_pkg::count_inc(rec.count);
					step.ev0_valid = 1'b1;
					step.ev0       = '{kind: msbs_pkg::KIND_EVENT, channel: slot_ch,
						level: item.force_level, status: msbs_pkg::QS_NONE};
				end
			end
			// Report the slot state; always one answer.
			msbs_pkg::OP_QUERY: begin
				step.ev0_valid = 1'b1;
				step.ev0       = '{kind: msbs_pkg::KIND_QUERY, channel: item.channel_id,
					level: 1'b0,
					status: !found ? msbs_pkg::QS_NONE :
						(rec.started ? msbs_pkg::QS_ACTIVE : msbs_pkg::QS_IDLE)};
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/multi_slot_blink_scheduler_top.sv
// Flow: an enabled set, remove, force or query item passes the read, multiply, update and
// drain steps and then the flush step, where its last result is presented; a query while
// disabled goes straight to the flush step. Output stalls hold the drain and flush steps.
// A tick item walks every slot in turn through a read, a multiply, an update and a drain step
// on the slot memory; a new item is accepted only once the sequencer is back in idle.
// Reset clears the slot table valid bits, the tick counter and all control state at once;
// items are accepted from the first cycle after reset.
`default_nettype none

module multi_slot_blink_scheduler_top #(
	parameter int SLOTS = msbs_pkg::SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input items.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// channel_id[7:0], on_time[23:8], dark_time[39:24], cycle_limit[55:40],
	// start_delay[71:56], force_level[72], zero fill above.
	input  wire logic [79:0] s_tdata,
	// op[2:0].
	input  wire logic [2:0]  s_tuser,
	// Result items.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_channel[7:0], out_level[8], query_status[10:9], zero fill above.
	output logic      [15:0] m_tdata,
	// kind[0].
	output logic             m_tuser,
	output logic             m_tlast,
	// Configuration.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	msbs_pkg::state_t    state_q, state_d;
	logic [15:0]         tpm;
	logic [31:0]         tick_now_q;
	logic [7:0]          id_q [SLOTS];
	logic [IDX_W-1:0]    idx_q;
	logic                found_q;
	msbs_pkg::item_t     item_q;
	msbs_pkg::item_t     in_item;
	msbs_pkg::slot_rec_t rd_rec;
	msbs_pkg::slot_rec_t rec_s2;
	logic [31:0]         prod_s2;
	logic [15:0]         phase_ms;
	msbs_pkg::step_out_t step;
	msbs_pkg::event_t    evb0_q, evb1_q;
	logic [1:0]          ev_n_q;
	msbs_pkg::event_t    pend_q;
	logic                pend_valid_q;
	msbs_pkg::event_t    out_q;
	logic                out_last_q;
	logic                m_tvalid_q;

	logic                accept;
	logic                enabled;
	logic                run_go;
	logic                tick_go;
	logic                dis_query;
	logic                mem_rd;
	logic                mem_we;
	logic                ev_take;
	logic                next_slot;
	logic                out_free;
	logic                out_load;
	logic                out_last_d;
	logic                loc_found;
	logic [IDX_W-1:0]    loc_idx;

	// Register port.
	msbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tick_rate (tpm)
	);

	// Unpack the incoming item.
	assign in_item = '{op: msbs_pkg::op_t'(s_tuser), channel_id: s_tdata[7:0],
		on_time: s_tdata[23:8], dark_time: s_tdata[39:24], cycle_limit: s_tdata[55:40],
		start_delay: s_tdata[71:56], force_level: s_tdata[72]};

	assign s_tready = (state_q == msbs_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign enabled  = (tpm != 16'd0);
	assign run_go   = accept && enabled && msbs_pkg::op_known(s_tuser);
	assign tick_go  = run_go && (in_item.op == msbs_pkg::OP_TICK);

	// Slot lookup: matching id first, else the first free slot.
	always_comb begin
		logic             match_hit;
		logic             free_hit;
		logic [IDX_W-1:0] match_idx;
		logic [IDX_W-1:0] free_idx;
		match_hit = 1'b0;
		free_hit  = 1'b0;
		match_idx = '0;
		free_idx  = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!match_hit && (id_q[i] == in_item.channel_id)) begin
				match_hit = 1'b1;
				match_idx = IDX_W'(i);
			end
			if (!free_hit && (id_q[i] == 8'd0)) begin
				free_hit = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
		loc_found = match_hit | free_hit;
		loc_idx   = match_hit ? match_idx : free_idx;
	end

	// Slot record memory.
	msbs_slot_mem #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd),
		.rd_addr (idx_q),
		.rd_rec  (rd_rec),
		.wr_en   (mem_we),
		.wr_addr (idx_q),
		.wr_rec  (step.rec)
	);

	// Length of the running phase in ms, chosen from the fresh record.
	assign phase_ms = !rd_rec.started ? rd_rec.delay :
		(rd_rec.level ? rd_rec.on_time : rd_rec.dark_time);

	// Per-slot update.
	msbs_step u_step (
		.item     (item_q),
		.found    (found_q),
		.slot_ch  (id_q[idx_q]),
		.tick_now (tick_now_q),
		.rec      (rec_s2),
		.prod     (prod_s2),
		.step     (step)
	);

	assign mem_we   = (state_q == msbs_pkg::ST_EXEC) && step.rec_we;
	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer: next state and control strobes.
	always_comb begin
		state_d    = state_q;
		dis_query  = 1'b0;
		mem_rd     = 1'b0;
		ev_take    = 1'b0;
		next_slot  = 1'b0;
		out_load   = 1'b0;
		out_last_d = 1'b0;
		unique case (state_q)
			msbs_pkg::ST_IDLE: begin
				if (run_go) begin
					state_d = msbs_pkg::ST_READ;
				end else if (accept && (in_item.op == msbs_pkg::OP_QUERY)) begin
					dis_query = 1'b1;
					state_d   = msbs_pkg::ST_FLUSH;
				end
			end
			msbs_pkg::ST_READ: begin
				mem_rd  = 1'b1;
				state_d = msbs_pkg::ST_MUL;
			end
			msbs_pkg::ST_MUL: begin
				state_d = msbs_pkg::ST_EXEC;
			end
			msbs_pkg::ST_EXEC: begin
				state_d = msbs_pkg::ST_DRAIN;
			end
			msbs_pkg::ST_DRAIN: begin
				if (ev_n_q == 2'd0) begin
					if ((item_q.op == msbs_pkg::OP_TICK) && (idx_q != LAST_IDX)) begin
						next_slot = 1'b1;
						state_d   = msbs_pkg::ST_READ;
					end else begin
						state_d = msbs_pkg::ST_FLUSH;
					end
				end else if (!pend_valid_q || out_free) begin
					// The held result is known not to be the last one.
					ev_take  = 1'b1;
					out_load = pend_valid_q;
				end
			end
			msbs_pkg::ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = msbs_pkg::ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_last_d = 1'b1;
					state_d    = msbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = msbs_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= msbs_pkg::ST_IDLE;
			tick_now_q   <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			ev_n_q       <= '0;
			pend_valid_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				id_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (tick_go) begin
				tick_now_q <= tick_now_q + 32'd1;
				idx_q      <= '0;
			end else if (run_go) begin
				idx_q   <= loc_idx;
				found_q <= loc_found;
			end else if (next_slot) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (mem_we && step.id_we) begin
				id_q[idx_q] <= step.id;
			end
			// Event buffer of one slot step.
			if (state_q == msbs_pkg::ST_EXEC) begin
				ev_n_q <= step.ev1_valid ? 2'd2 : (step.ev0_valid ? 2'd1 : 2'd0);
			end else if (ev_take) begin
				ev_n_q <= ev_n_q - 2'd1;
			end
			// One result is held back until it is known whether it is the last.
			if (ev_take || dis_query) begin
				pend_valid_q <= 1'b1;
			end else if (out_load && out_last_d) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
		if (state_q == msbs_pkg::ST_MUL) begin
			rec_s2  <= rd_rec;
			prod_s2 <= {16'd0, phase_ms} * {16'd0, tpm};
		end
		if (state_q == msbs_pkg::ST_EXEC) begin
			evb0_q <= step.ev0;
			evb1_q <= step.ev1;
		end else if (ev_take) begin
			evb0_q <= evb1_q;
		end
		if (ev_take) begin
			pend_q <= evb0_q;
		end else if (dis_query) begin
			pend_q <= '{kind: msbs_pkg::KIND_QUERY, channel: in_item.channel_id,
				level: 1'b0, status: msbs_pkg::QS_NONE};
		end
		if (out_load) begin
			out_q      <= pend_q;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, out_q.status, out_q.level, out_q.channel};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_last_q;

	// A slot step yields at most two results.
	a_ev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ev_n_q != 2'd3)
		else $error("event buffer overfilled");

	// No result may be left behind when the next item can be accepted.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msbs_pkg::ST_IDLE) |-> (!pend_valid_q && (ev_n_q == 2'd0)))
		else $error("result pending while idle");

	// Time only advances on an accepted tick.
	a_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_now_q != $past(tick_now_q)) |-> $past(tick_go))
		else $error("tick counter moved without a tick item");

	// The slot memory is written only in the update step.
	a_write_step: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ($past(state_q) == msbs_pkg::ST_MUL))
		else $error("slot write outside update step");

endmodule

`default_nettype wire

// File: dv/msbs_result_checker.sv
`default_nettype none

// Watches the item channels and the configuration port of the blink scheduler, keeps its own
// copy of the slot table, and compares every result item against the predicted one.
module msbs_result_checker #(
	parameter int         SLOTS    = msbs_pkg::SLOTS_DEF,
	parameter logic [2:0] TPM_ADDR = 3'd0
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [79:0] s_tdata,
	input  wire logic [2:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               mismatches,
	output int               outstanding
);

	// One result item as it should appear on the master side.
	typedef struct packed {
		logic       kind;
		logic [7:0] channel;
		logic       level;
		logic [1:0] status;
		logic       last;
	} blink_result_t;

	blink_result_t pending_results[$];

	// Shadow of the configuration and the slot table.
	logic [15:0]                  tick_rate;
	logic [7:0]                   chan_id   [SLOTS];
	logic [15:0]                  on_ms     [SLOTS];
	logic [15:0]                  off_ms    [SLOTS];
	logic [15:0]                  delay_ms  [SLOTS];
	logic [15:0]                  limit_cnt [SLOTS];
	logic [msbs_pkg::COUNT_W-1:0] changes   [SLOTS];
	logic [31:0]                  phase_t0  [SLOTS];
	logic                         running   [SLOTS];
	logic                         lit       [SLOTS];
	logic [31:0]                  now_ticks;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic void post_result(input logic kind, input logic [7:0] ch,
			input logic lvl, input logic [1:0] st);
		blink_result_t r;
		r.kind    = kind;
		r.channel = ch;
		r.level   = lvl;
		r.status  = st;
		r.last    = 1'b0;
		pending_results.push_back(r);
	endfunction

	// Every drive emits an event, even when the level does not change.
	function automatic void drive_level(input int i, input logic lvl);
		lit[i] = lvl;
		post_result(msbs_pkg::KIND_EVENT, chan_id[i], lvl, msbs_pkg::QS_NONE);
		if (changes[i] != {msbs_pkg::COUNT_W{1'b1}})
			changes[i] = changes[i] + 1'b1;
	endfunction

	// Elapsed ticks wrap at 32 bits; the product of ms and rate always fits.
	function automatic logic phase_done(input int i, input logic [15:0] ms);
		logic [31:0] elapsed;
		elapsed = now_ticks - phase_t0[i];
		return elapsed >= ({16'd0, ms} * {16'd0, tick_rate});
	endfunction

	// End of a phase: go on to the next level, or free the slot when the limit is spent.
	function automatic void end_phase(input int i, input logic nxt);
		phase_t0[i] = now_ticks;
		if (limit_cnt[i] != 16'd0 && {1'b0, limit_cnt[i]} >= changes[i]) begin
			drive_level(i, nxt);
		end else begin
			running[i] = 1'b0;
			drive_level(i, 1'b0);
			chan_id[i] = 8'd0;
		end
	endfunction

	function automatic void step_slot(input int i);
		if (chan_id[i] == 8'd0)
			return;
		if (!running[i] && phase_done(i, delay_ms[i])) begin
			running[i]  = 1'b1;
			phase_t0[i] = now_ticks;
			drive_level(i, 1'b1);
		end
		// A zero ON time can end in the very tick that the delay expired.
		if (running[i]) begin
			if (lit[i]) begin
				if (phase_done(i, on_ms[i]))
					end_phase(i, off_ms[i] == 16'd0);
			end else if (phase_done(i, off_ms[i])) begin
				end_phase(i, 1'b1);
			end
		end
	endfunction

	// Matching id first, else the first free slot, else none.
	function automatic int find_slot(input logic [7:0] ch);
		int first;
		first = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (chan_id[i] == ch)
				return i;
			if (first < 0 && chan_id[i] == 8'd0)
				first = i;
		end
		return first;
	endfunction

	// Works out the results of one accepted item and appends them to the expected list.
	function automatic void apply_command(input logic [79:0] data, input logic [2:0] op);
		logic [7:0]  ch;
		logic [15:0] dly;
		int          idx;
		int          base;
		ch   = data[7:0];
		dly  = data[71:56];
		base = pending_results.size();
		if (tick_rate == 16'd0) begin
			if (op == msbs_pkg::OP_QUERY)
				post_result(msbs_pkg::KIND_QUERY, ch, 1'b0, msbs_pkg::QS_NONE);
		end else begin
			case (op)
				msbs_pkg::OP_TICK: begin
					now_ticks = now_ticks + 32'd1;
					for (int i = 0; i < SLOTS; i++)
						step_slot(i);
				end
				msbs_pkg::OP_SET: begin
					idx = find_slot(ch);
					if (idx >= 0) begin
						on_ms[idx]     = data[23:8];
						off_ms[idx]    = data[39:24];
						limit_cnt[idx] = data[55:40];
						delay_ms[idx]  = dly;
						changes[idx]   = '0;
						phase_t0[idx]  = now_ticks;
						chan_id[idx]   = ch;
						running[idx]   = 1'b0;
						if (dly == 16'd0) begin
							running[idx] = 1'b1;
							drive_level(idx, 1'b1);
						end
					end
				end
				msbs_pkg::OP_REMOVE: begin
					idx = find_slot(ch);
					if (idx >= 0) begin
						drive_level(idx, 1'b0);
						running[idx] = 1'b0;
						chan_id[idx] = 8'd0;
					end
				end
				msbs_pkg::OP_FORCE: begin
					idx = find_slot(ch);
					if (idx >= 0)
						drive_level(idx, data[72]);
				end
				msbs_pkg::OP_QUERY: begin
					idx = find_slot(ch);
					if (idx < 0)
						post_result(msbs_pkg::KIND_QUERY, ch, 1'b0, msbs_pkg::QS_NONE);
					else
						post_result(msbs_pkg::KIND_QUERY, ch, 1'b0,
							running[idx] ? msbs_pkg::QS_ACTIVE : msbs_pkg::QS_IDLE);
				end
				default: begin
				end
			endcase
		end
		if (pending_results.size() > base)
			pending_results[pending_results.size() - 1].last = 1'b1;
	endfunction

	function automatic void check_result();
		blink_result_t got;
		blink_result_t want;
		got.kind    = m_tuser;
		got.channel = m_tdata[7:0];
		got.level   = m_tdata[8];
		got.status  = m_tdata[10:9];
		got.last    = m_tlast;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: kind %0d ch %0d level %0d status %0d last %0d",
					got.kind, got.channel, got.level, got.status, got.last);
		end else begin
			want = pending_results.pop_front();
			if (got != want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result mismatch: expected kind %0d ch %0d level %0d status %0d ",
						"last %0d, got kind %0d ch %0d level %0d status %0d last %0d"},
						want.kind, want.channel, want.level, want.status, want.last,
						got.kind, got.channel, got.level, got.status, got.last);
			end
		end
	endfunction

	// Results are compared before the item accepted at the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate = 16'd0;
			now_ticks = 32'd0;
			for (int i = 0; i < SLOTS; i++) begin
				chan_id[i]   = 8'd0;
				on_ms[i]     = 16'd0;
				off_ms[i]    = 16'd0;
				delay_ms[i]  = 16'd0;
				limit_cnt[i] = 16'd0;
				changes[i]   = '0;
				phase_t0[i]  = 32'd0;
				running[i]   = 1'b0;
				lit[i]       = 1'b0;
			end
			pending_results.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (psel && penable && pwrite && pready && paddr == TPM_ADDR)
				tick_rate = pwdata[15:0];
			if (s_tvalid && s_tready)
				apply_command(s_tdata, s_tuser);
			outstanding = pending_results.size();
		end
	end

endmodule

`default_nettype wire

// File: dv/tb_multi_slot_blink_scheduler_top.sv
`default_nettype none

module tb_multi_slot_blink_scheduler_top;

	// Register 0 (the tick rate) sits at byte address 0.
	localparam logic [2:0] TPM_ADDR      = 3'd0;
	// Quiet time after the last expected result; it covers any work still in flight.
	localparam int         SETTLE_CYCLES = 40;

	// One command as the sender presents it.
	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  channel_id;
		logic [15:0] on_time;
		logic [15:0] dark_time;
		logic [15:0] cycle_limit;
		logic [15:0] start_delay;
		logic        force_level;
	} blink_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int idle_send;
	int idle_recv;
	int mismatches;
	int outstanding;

	multi_slot_blink_scheduler_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	msbs_result_checker #(
		.SLOTS   (msbs_pkg::SLOTS_DEF),
		.TPM_ADDR(TPM_ADDR)
	) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always #10 clk = ~clk;

	// The receiver stalls at random with the current idle rate.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= idle_recv);
	end

	function automatic blink_cmd_t cmd(input logic [2:0] op, input logic [7:0] ch,
			input logic [15:0] on_t, input logic [15:0] off_t, input logic [15:0] lim,
			input logic [15:0] dly, input logic lvl);
		blink_cmd_t c;
		c.op          = op;
		c.channel_id  = ch;
		c.on_time     = on_t;
		c.dark_time   = off_t;
		c.cycle_limit = lim;
		c.start_delay = dly;
		c.force_level = lvl;
		return c;
	endfunction

	// Mostly short times so that phases expire; now and then any 16-bit value.
	function automatic logic [15:0] rand_ms(input int top);
		if ($urandom_range(7) == 0)
			return 16'($urandom);
		return 16'($urandom_range(top));
	endfunction

	// Well-formed traffic on a small pool of channels, with a little noise.
	function automatic blink_cmd_t rand_cmd();
		blink_cmd_t c;
		int         roll;
		roll = $urandom_range(99);
		if (roll < 48)
			c.op = msbs_pkg::OP_TICK;
		else if (roll < 68)
			c.op = msbs_pkg::OP_SET;
		else if (roll < 78)
			c.op = msbs_pkg::OP_QUERY;
		else if (roll < 86)
			c.op = msbs_pkg::OP_FORCE;
		else if (roll < 94)
			c.op = msbs_pkg::OP_REMOVE;
		else
			c.op = 3'($urandom_range(7));
		if ($urandom_range(9) == 0)
			c.channel_id = 8'($urandom_range(255, 1));
		else
			c.channel_id = 8'($urandom_range(5, 1));
		c.on_time     = rand_ms(4);
		c.dark_time   = rand_ms(3);
		c.cycle_limit = rand_ms(8);
		c.start_delay = rand_ms(3);
		c.force_level = 1'($urandom_range(1));
		return c;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance, valid still high.
	task automatic send_item(input blink_cmd_t c);
		while ($urandom_range(99) < idle_send) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, c.force_level, c.start_delay, c.cycle_limit, c.dark_time,
			c.on_time, c.channel_id};
		s_tuser  <= c.op;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Holds off the sender until every expected result has come and the block is quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_tick_rate(input logic [15:0] value);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TPM_ADDR;
		pwdata  <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Ignored op codes do not count toward the item total.
	task automatic run_random(input int count, input int pause_at);
		blink_cmd_t c;
		int         sent;
		sent = 0;
		while (sent < count) begin
			c = rand_cmd();
			send_item(c);
			if (c.op <= msbs_pkg::OP_QUERY) begin
				sent++;
				if (sent == pause_at)
					drain();
			end
		end
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		idle_send = 7;
		idle_recv = 45;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Disabled: only a query answers, with no slot found.
		send_item(cmd(msbs_pkg::OP_QUERY, 8'd5, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		send_item(cmd(msbs_pkg::OP_TICK, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		send_item(cmd(msbs_pkg::OP_SET, 8'd1, 16'd1, 16'd1, 16'd1, 16'd0, 1'b0));
		write_tick_rate(16'd1);

		// Unknown id with a free slot answers as not started.
		send_item(cmd(msbs_pkg::OP_QUERY, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		// Zero times and a zero limit: on at once, then freed on the next tick.
		send_item(cmd(msbs_pkg::OP_SET, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		send_item(cmd(msbs_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		// Fill all three slots: delayed start, longest times, and steady ON.
		send_item(cmd(msbs_pkg::OP_SET, 8'd2, 16'd1, 16'd1, 16'd3, 16'd2, 1'b0));
		send_item(cmd(msbs_pkg::OP_SET, 8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1));
		send_item(cmd(msbs_pkg::OP_SET, 8'd4, 16'd2, 16'd0, 16'd5, 16'd0, 1'b0));
		// Table full: set, force and query of a new id find nothing.
		send_item(cmd(msbs_pkg::OP_SET, 8'd7, 16'd1, 16'd1, 16'd1, 16'hFFFF, 1'b0));
		send_item(cmd(msbs_pkg::OP_FORCE, 8'd9, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
		send_item(cmd(msbs_pkg::OP_QUERY, 8'd7, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		send_item(cmd(msbs_pkg::OP_FORCE, 8'd3, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		send_item(cmd(msbs_pkg::OP_QUERY, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		repeat (4) send_item(cmd(msbs_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		// Removing a known id, then an unknown one, which drives the free slot as channel 0.
		send_item(cmd(msbs_pkg::OP_REMOVE, 8'd4, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		send_item(cmd(msbs_pkg::OP_REMOVE, 8'd200, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		// Channel zero matches the free slot like any other id.
		send_item(cmd(msbs_pkg::OP_SET, 8'd0, 16'd1, 16'd1, 16'd2, 16'd0, 1'b0));
		send_item(cmd(msbs_pkg::OP_FORCE, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
		// Unused op codes are dropped.
		send_item(cmd(3'd5, 8'd3, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
		send_item(cmd(3'd7, 8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		send_item(cmd(msbs_pkg::OP_QUERY, 8'd3, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));

		run_random(100, 50);
		write_tick_rate(16'hFFFF);
		run_random(20, 0);

		idle_send = 45;
		idle_recv = 7;
		write_tick_rate(16'd2);
		run_random(100, 60);

		idle_send = 0;
		idle_recv = 0;
		write_tick_rate(16'd3);
		run_random(80, 0);

		drain();
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#12000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
